// File: rtl/core/esd_pkg.sv
// Shared types, character codes and helpers for the escape sequence decoder.
package esd_pkg;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned FIFO_DEPTH = 4;

  // Most output bytes that one input byte can produce.
  localparam int unsigned MAX_BYTES = 4;

  // Character codes used by the decoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Offset from a letter's low nibble to its hex digit value.
  localparam logic [3:0] HEX_ALPHA_ADJ = 4'd9;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Group of output bytes produced by one input byte.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } bundle_t;

  // Escape parsing phase.
  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_SLASH = 4'b0010,
    PH_X     = 4'b0100,
    PH_DIGIT = 4'b1000
  } phase_t;

  // Returns {is_hex, digit value} for one character.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      res = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      res = {1'b1, c[3:0] + HEX_ALPHA_ADJ};
    end
    return res;
  endfunction

endpackage

// File: rtl/core/esd_front.sv
// Front part: accepts input bytes, tracks escape state and builds output byte groups.
module esd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              crlf_mode,
  input  logic              in_valid,
  output logic              in_stall,
  input  esd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output esd_pkg::bundle_t  q_data
);

  esd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      held_digit_r, held_digit_nxt;

  logic                               accept;
  logic [esd_pkg::MAX_BYTES-1:0][7:0] eb;
  logic [2:0]                         n;
  logic                               plain_go;
  logic [4:0]                         hv_b;
  logic [4:0]                         hv_h;
  logic [7:0]                         b;

  // The queue being full is the only reason to hold off the sender.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_data.in_byte;
  assign hv_b     = esd_pkg::hex_decode(b);
  assign hv_h     = esd_pkg::hex_decode(held_digit_r);

  // Decode one byte into zero to four output bytes and the next phase.
  always_comb begin
    eb             = '0;
    n              = 3'd0;
    phase_nxt      = phase_r;
    held_digit_nxt = held_digit_r;
    plain_go       = 1'b0;
    case (phase_r)
      esd_pkg::PH_PLAIN: begin
        plain_go = 1'b1;
      end
      esd_pkg::PH_SLASH: begin
        phase_nxt = esd_pkg::PH_PLAIN;
        if (b == esd_pkg::CH_LOWER_T) begin
          eb[0] = esd_pkg::CH_TAB;
          n     = 3'd1;
        end else if (b == esd_pkg::CH_LOWER_N) begin
          if (crlf_mode) begin
            eb[0] = esd_pkg::CH_CR;
            eb[1] = esd_pkg::CH_LF;
            n     = 3'd2;
          end else begin
            eb[0] = esd_pkg::CH_LF;
            n     = 3'd1;
          end
        end else if (b == esd_pkg::CH_BSLASH) begin
          eb[0] = esd_pkg::CH_BSLASH;
          n     = 3'd1;
        end else if (b == esd_pkg::CH_LOWER_X) begin
          phase_nxt = esd_pkg::PH_X;
        end else begin
          eb[0]    = esd_pkg::CH_BSLASH;
          n        = 3'd1;
          plain_go = 1'b1;
        end
      end
      esd_pkg::PH_X: begin
        if (hv_b[4]) begin
          held_digit_nxt = b;
          phase_nxt      = esd_pkg::PH_DIGIT;
        end else begin
          phase_nxt = esd_pkg::PH_PLAIN;
          eb[0]     = esd_pkg::CH_BSLASH;
          eb[1]     = esd_pkg::CH_LOWER_X;
          n         = 3'd2;
          plain_go  = 1'b1;
        end
      end
      esd_pkg::PH_DIGIT: begin
        phase_nxt = esd_pkg::PH_PLAIN;
        if (hv_b[4]) begin
          eb[0] = {hv_h[3:0], hv_b[3:0]};
          n     = 3'd1;
        end else begin
          eb[0]    = esd_pkg::CH_BSLASH;
          eb[1]    = esd_pkg::CH_LOWER_X;
          eb[2]    = held_digit_r;
          n        = 3'd3;
          plain_go = 1'b1;
        end
      end
      default: begin
        phase_nxt = esd_pkg::PH_PLAIN;
      end
    endcase

    // Plain text handling: a backslash opens an escape, anything else passes.
    if (plain_go) begin
      if (b == esd_pkg::CH_BSLASH) begin
        phase_nxt = esd_pkg::PH_SLASH;
      end else begin
        eb[n[1:0]] = b;
        n          = n + 3'd1;
      end
    end

    // At the end of the string, flush any held escape bytes literally.
    if (in_data.in_last) begin
      case (phase_nxt)
        esd_pkg::PH_SLASH: begin
          eb[n[1:0]] = esd_pkg::CH_BSLASH;
          n          = n + 3'd1;
        end
        esd_pkg::PH_X: begin
          eb[0] = esd_pkg::CH_BSLASH;
          eb[1] = esd_pkg::CH_LOWER_X;
          n     = 3'd2;
        end
        esd_pkg::PH_DIGIT: begin
          eb[0] = esd_pkg::CH_BSLASH;
          eb[1] = esd_pkg::CH_LOWER_X;
          eb[2] = held_digit_nxt;
          n     = 3'd3;
        end
        default: begin
        end
      endcase
      phase_nxt = esd_pkg::PH_PLAIN;
    end
  end

  // Only groups that carry bytes enter the queue.
  assign q_push       = accept && (n != 3'd0);
  assign q_data.bytes = eb;
  assign q_data.cnt   = n;
  assign q_data.last  = in_data.in_last;

  // Escape state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= esd_pkg::PH_PLAIN;
      held_digit_r <= 8'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      held_digit_r <= held_digit_nxt;
    end
  end

endmodule

// File: rtl/core/esd_fifo.sv
// Short queue of output byte groups between the front and back parts.
module esd_fifo #(
  parameter int unsigned DEPTH = esd_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  esd_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output esd_pkg::bundle_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  esd_pkg::bundle_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and occupancy updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/esd_back.sv
// Back part: walks each queued byte group and presents one byte per output transaction.
module esd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  esd_pkg::bundle_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output esd_pkg::out_item_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  esd_pkg::out_item_t out_r, out_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               can_load;
  logic               at_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign can_load  = !out_valid_r || !out_stall;
  assign at_end    = ({1'b0, idx_r} == (q_head.cnt - 3'd1));
  assign q_pop     = can_load && !q_empty && at_end;

  // Load the output register from the current group whenever it frees up.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    if (can_load) begin
      if (!q_empty) begin
        out_valid_nxt    = 1'b1;
        out_nxt.out_byte = q_head.bytes[idx_r];
        out_nxt.out_last = q_head.last && at_end;
        idx_nxt          = at_end ? 2'd0 : idx_r + 2'd1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: rtl/core/escape_sequence_decoder.sv
// Top level of the backslash escape decoder: configuration register, front, queue and back.
// An input byte's first output byte passes through the queue and then the output register.
// Throughput: one input byte per cycle while the queue has room, one output byte per cycle
// while out_stall is low; a group of up to four bytes holds the back part till all are out.
// The queue between front and back absorbs such bursts; input stalls only when it is full.
// Synchronous active-low reset clears the escape phase, the queue, the output and crlf_mode.
module escape_sequence_decoder #(
  parameter int unsigned FifoDepth = esd_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  esd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output esd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic             crlf_mode_r;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  esd_pkg::bundle_t q_in;
  esd_pkg::bundle_t q_head;

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crlf_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      crlf_mode_r <= cfg_data;
    end
  end

  // Escape parsing.
  esd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .crlf_mode (crlf_mode_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Byte group queue.
  esd_fifo #(
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Byte emission.
  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
